// ----- hw/rtl/ubxnav_pkg.sv -----
// Shared types and constants of the UBX navigation frame parser.
// No dependencies; every other file of the block but the payload buffer imports this package.
`default_nettype none

package ubxnav_pkg;

   // Frame framing bytes.
   localparam logic [7:0] SYNC_A    = 8'hB5;
   localparam logic [7:0] SYNC_B    = 8'h62;
   localparam logic [7:0] CLASS_NAV = 8'h01;
   localparam logic [7:0] ID_POSLLH = 8'h02;
   localparam logic [7:0] ID_STATUS = 8'h03;
   localparam logic [7:0] ID_VELNED = 8'h12;

   // Reciprocals of the velocity frame's constant divisors: a 32-bit value
   // divided by 5 is (x * SPEED_RECIP) >> SPEED_SHIFT, and by 1000 it is
   // (x * HEADING_RECIP) >> HEADING_SHIFT, exact over the full 32-bit range.
   localparam logic [31:0] SPEED_RECIP   = 32'hCCCC_CCCD;
   localparam int unsigned SPEED_SHIFT   = 34;
   localparam logic [31:0] HEADING_RECIP = 32'h1062_4DD3;
   localparam int unsigned HEADING_SHIFT = 38;

   // Width of the divider's dividend magnitude and quotient magnitude.
   localparam int unsigned DIV_W = 32;

   // Payload fetch plan: byte slot k maps to payload offset k, except in
   // velocity frames where slots from four on map to offset k plus 16.
   localparam logic [3:0] FETCH_LAST_LONG = 4'd11;
   localparam logic [3:0] FETCH_LAST_STAT = 4'd4;
   localparam logic [3:0] VEL_TAIL_SLOT   = 4'd4;
   localparam logic [4:0] VEL_TAIL_SKIP   = 5'd16;
   localparam int unsigned FETCH_SLOTS    = 12;

   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_LAT = 2'd0,
      CSR_ORIGIN_LON = 2'd1,
      CSR_SCALE_LAT  = 2'd2,
      CSR_SCALE_LON  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FRAME_POS  = 2'd0,
      FRAME_VEL  = 2'd1,
      FRAME_STAT = 2'd2
   } frame_kind_type;

   // Parser to sequencer: the current byte, if taken, commits a known frame.
   typedef struct packed {
      logic           commit;
      frame_kind_type kind;
   } parse_status_type;

   // Sequencer to divider: sign and magnitude of the dividend, divisor.
   typedef struct packed {
      logic              neg;
      logic [DIV_W-1:0]  mag;
      logic [30:0]       divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ubxnav_payload_ram.sv -----
// Payload buffer of the UBX parser: one write port, one read port with a
// registered read. Depends on nothing.
`default_nettype none

module ubxnav_payload_ram #(
   parameter int unsigned PAYLOAD_BYTES = 64,
   parameter int unsigned ADDR_W        = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [PAYLOAD_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ubxnav_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, sign applied at
// the end so the result truncates toward zero. Depends on ubxnav_pkg.
`default_nettype none

module ubxnav_divider
   import ubxnav_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire div_req_type       req,
   output logic                   done,
   output logic signed [DIV_W:0]  quotient
);

   localparam int unsigned CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic             neg_ff;
   logic [30:0]      rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [30:0]      divisor_ff;

   logic [31:0] shifted;
   logic [31:0] trial;
   logic        take;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign take    = shifted >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            count_ff   <= '0;
            neg_ff     <= req.neg;
            rem_ff     <= '0;
            quo_ff     <= req.mag;
            divisor_ff <= req.divisor;
         end else if (busy_ff) begin
            // The remainder stays below the divisor, so its top bit is free.
            rem_ff   <= take ? trial[30:0] : shifted[30:0];
            quo_ff   <= {quo_ff[DIV_W-2:0], take};
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/ubxnav_byte_parser.sv -----
// Byte-level framing of the UBX stream: sync hunt, header, payload writes
// into the payload buffer, checksum skip. Depends on ubxnav_pkg.
`default_nettype none

module ubxnav_byte_parser
   import ubxnav_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 64,
   parameter int unsigned ADDR_W        = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_take,
   input  wire logic [7:0]        rx_byte,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data,
   output parse_status_type       status
);

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_CLASS   = 3'd2,
      PH_ID      = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_LEN_HI  = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_CKSUM_B = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;

   logic more_payload;
   logic in_buffer;

   assign more_payload = count_ff < length_ff;
   assign in_buffer    = count_ff < 16'(PAYLOAD_BYTES);

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      if (byte_take) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == SYNC_A) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == SYNC_B) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
               class_in = rx_byte;
               phase_in = PH_ID;
            end
            PH_ID: begin
               id_in    = rx_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {length_ff[15:8], rx_byte};
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = {rx_byte, length_ff[7:0]};
               count_in  = '0;
               phase_in  = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               // Once the payload is complete this byte is the first checksum byte.
               if (more_payload) begin
                  count_in = count_ff + 16'd1;
               end else begin
                  phase_in = PH_CKSUM_B;
               end
            end
            PH_CKSUM_B: begin
               phase_in = PH_SYNC1;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // Bytes past the end of the buffer are counted but not stored.
   assign wr_en   = byte_take && (phase_ff == PH_PAYLOAD) && more_payload && in_buffer;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = rx_byte;

   always_comb begin
      status.kind = FRAME_POS;
      case (id_ff)
         ID_POSLLH: status.kind = FRAME_POS;
         ID_VELNED: status.kind = FRAME_VEL;
         ID_STATUS: status.kind = FRAME_STAT;
         default:   status.kind = FRAME_POS;
      endcase
      status.commit = (phase_ff == PH_CKSUM_B) && (class_ff == CLASS_NAV)
                   && (id_ff == ID_POSLLH || id_ff == ID_VELNED || id_ff == ID_STATUS);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ubx_nav_frame_parser_top.sv -----
// UBX navigation frame parser, top level.
//
// Bytes of the stream enter on req_ (req_rx_byte), one transfer per byte.
// Results leave on rsp_, one transfer per committed NAV-POSLLH, NAV-VELNED
// or NAV-STATUS frame, carrying every held navigation value. The csr_
// channel writes the four registers (origins and scales); it is always
// ready and is meant to be written while the block is idle.
// Ordinary bytes are taken one per cycle. On the byte that commits a known
// frame the block stops taking bytes while it reads the needed payload bytes
// back from the payload buffer, one per cycle over its single read port.
// A position frame then runs the shared one-bit-per-cycle divider twice.
// A velocity frame divides by its constants with one shared reciprocal
// multiplier, one quotient per cycle; a status frame needs no division.
// The result sits in an output register, so bytes keep flowing while it
// waits; a second commit waits in the final stage until rsp_ready frees it.
// Reset (synchronous) returns the parser to sync hunting and zeroes all
// held values; the payload buffer is not cleared.
// Depends on ubxnav_pkg, ubxnav_byte_parser, ubxnav_payload_ram and
// ubxnav_divider.
`default_nettype none

module ubx_nav_frame_parser_top
   import ubxnav_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_frame_type,
   output logic [31:0]               rsp_time_of_week,
   output logic signed [31:0]        rsp_longitude,
   output logic signed [31:0]        rsp_latitude,
   output logic signed [32:0]        rsp_north_distance,
   output logic signed [32:0]        rsp_east_distance,
   output logic signed [22:0]        rsp_heading,
   output logic [29:0]               rsp_ground_speed,
   output logic [7:0]                rsp_fix_type,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(PAYLOAD_BYTES);

   typedef enum logic [2:0] {
      SQ_IDLE       = 3'd0,
      SQ_FETCH      = 3'd1,
      SQ_FETCH_LAST = 3'd2,
      SQ_DIV1_GO    = 3'd3,
      SQ_DIV1_WAIT  = 3'd4,
      SQ_DIV2_GO    = 3'd5,
      SQ_DIV2_WAIT  = 3'd6,
      SQ_EMIT       = 3'd7
   } seq_state_type;

   // Configuration registers.
   logic [31:0] origin_lat_ff, origin_lon_ff;
   logic [30:0] scale_lat_ff, scale_lon_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff <= '0;
         origin_lon_ff <= '0;
         scale_lat_ff  <= 31'd1;
         scale_lon_ff  <= 31'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_LAT: origin_lat_ff <= csr_wdata;
            CSR_ORIGIN_LON: origin_lon_ff <= csr_wdata;
            CSR_SCALE_LAT:  scale_lat_ff  <= csr_wdata[30:0];
            CSR_SCALE_LON:  scale_lon_ff  <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // Byte parser and payload buffer.
   seq_state_type     seq_state_ff, seq_state_in;
   logic              byte_take;
   parse_status_type  parse_status;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   assign req_ready = (seq_state_ff == SQ_IDLE);
   assign byte_take = req_valid && req_ready;

   ubxnav_byte_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .ADDR_W        (ADDR_W)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .status    (parse_status)
   );

   ubxnav_payload_ram #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .ADDR_W        (ADDR_W)
   ) u_payload (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Commit sequencer state.
   frame_kind_type kind_ff;
   logic [3:0]     slot_ff;
   logic           cap_valid_ff;
   logic [3:0]     cap_slot_ff;
   logic [7:0]     fetch_data_ff [FETCH_SLOTS];
   logic [32:0]    quot1_ff, quot2_ff;

   logic [31:0] held_lon_ff, held_lat_ff;
   logic [32:0] held_north_ff, held_east_ff;
   logic [22:0] held_heading_ff;
   logic [29:0] held_speed_ff;
   logic [7:0]  held_fix_ff;
   logic        rsp_valid_ff;

   logic [31:0] word0, word1, word2;
   logic [3:0]  last_slot;
   logic [4:0]  slot_offset;
   logic        out_free;
   logic        emit;

   assign word0 = {fetch_data_ff[3], fetch_data_ff[2], fetch_data_ff[1], fetch_data_ff[0]};
   assign word1 = {fetch_data_ff[7], fetch_data_ff[6], fetch_data_ff[5], fetch_data_ff[4]};
   assign word2 = {fetch_data_ff[11], fetch_data_ff[10], fetch_data_ff[9], fetch_data_ff[8]};

   assign last_slot   = (kind_ff == FRAME_STAT) ? FETCH_LAST_STAT : FETCH_LAST_LONG;
   assign slot_offset = (kind_ff == FRAME_VEL && slot_ff >= VEL_TAIL_SLOT)
                      ? {1'b0, slot_ff} + VEL_TAIL_SKIP : {1'b0, slot_ff};
   assign ram_rd_en   = (seq_state_ff == SQ_FETCH);
   assign ram_rd_addr = ADDR_W'(slot_offset);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (seq_state_ff == SQ_EMIT) && out_free;

   // Divider operands: flat distances for position frames.
   logic        div_start;
   logic        div_second;
   div_req_type div_req;
   logic        div_done;
   logic [32:0] div_quot;
   logic [32:0] dividend;
   logic [30:0] scale_lat_eff, scale_lon_eff;

   assign div_start  = ((seq_state_ff == SQ_DIV1_GO) || (seq_state_ff == SQ_DIV2_GO))
                    && (kind_ff == FRAME_POS);
   assign div_second = (seq_state_ff == SQ_DIV2_GO);

   // Velocity frames: speed in the first step, heading in the second, both
   // through one multiplier. The heading divides its magnitude so the
   // quotient truncates toward zero.
   logic [31:0] heading_mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic [32:0] speed_quot, heading_quot;

   assign heading_mag  = word2[31] ? (32'd0 - word2) : word2;
   assign mul_a        = div_second ? heading_mag : word1;
   assign mul_b        = div_second ? HEADING_RECIP : SPEED_RECIP;
   assign product      = {32'd0, mul_a} * {32'd0, mul_b};
   assign speed_quot   = {3'd0, product[63:SPEED_SHIFT]};
   assign heading_quot = word2[31] ? (33'd0 - {7'd0, product[63:HEADING_SHIFT]})
                                   : {7'd0, product[63:HEADING_SHIFT]};

   // A zero scale behaves as a scale of one.
   assign scale_lat_eff = (scale_lat_ff == '0) ? 31'd1 : scale_lat_ff;
   assign scale_lon_eff = (scale_lon_ff == '0) ? 31'd1 : scale_lon_ff;

   always_comb begin
      dividend        = '0;
      div_req.divisor = 31'd1;
      case (kind_ff)
         FRAME_POS: begin
            if (div_second) begin
               dividend        = {word1[31], word1} - {origin_lon_ff[31], origin_lon_ff};
               div_req.divisor = scale_lon_eff;
            end else begin
               dividend        = {word2[31], word2} - {origin_lat_ff[31], origin_lat_ff};
               div_req.divisor = scale_lat_eff;
            end
         end
         default: begin
            dividend        = '0;
            div_req.divisor = 31'd1;
         end
      endcase
      div_req.neg = dividend[32];
      div_req.mag = dividend[32] ? DIV_W'(-dividend) : dividend[DIV_W-1:0];
   end

   ubxnav_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Values written back to the held state when the result is emitted.
   logic [31:0] nxt_lon, nxt_lat;
   logic [32:0] nxt_north, nxt_east;
   logic [22:0] nxt_heading;
   logic [29:0] nxt_speed;
   logic [7:0]  nxt_fix;

   always_comb begin
      nxt_lon     = held_lon_ff;
      nxt_lat     = held_lat_ff;
      nxt_north   = held_north_ff;
      nxt_east    = held_east_ff;
      nxt_heading = held_heading_ff;
      nxt_speed   = held_speed_ff;
      nxt_fix     = held_fix_ff;
      case (kind_ff)
         FRAME_POS: begin
            nxt_lon   = word1;
            nxt_lat   = word2;
            nxt_north = quot1_ff;
            nxt_east  = quot2_ff;
         end
         FRAME_VEL: begin
            nxt_speed   = quot1_ff[29:0];
            nxt_heading = quot2_ff[22:0];
         end
         FRAME_STAT: begin
            nxt_fix = fetch_data_ff[FETCH_LAST_STAT];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      seq_state_in = seq_state_ff;
      case (seq_state_ff)
         SQ_IDLE: begin
            if (byte_take && parse_status.commit) begin
               seq_state_in = SQ_FETCH;
            end
         end
         SQ_FETCH: begin
            if (slot_ff == last_slot) begin
               seq_state_in = SQ_FETCH_LAST;
            end
         end
         SQ_FETCH_LAST: begin
            seq_state_in = (kind_ff == FRAME_STAT) ? SQ_EMIT : SQ_DIV1_GO;
         end
         SQ_DIV1_GO: begin
            seq_state_in = (kind_ff == FRAME_VEL) ? SQ_DIV2_GO : SQ_DIV1_WAIT;
         end
         SQ_DIV1_WAIT: begin
            if (div_done) begin
               seq_state_in = SQ_DIV2_GO;
            end
         end
         SQ_DIV2_GO: begin
            seq_state_in = (kind_ff == FRAME_VEL) ? SQ_EMIT : SQ_DIV2_WAIT;
         end
         SQ_DIV2_WAIT: begin
            if (div_done) begin
               seq_state_in = SQ_EMIT;
            end
         end
         SQ_EMIT: begin
            if (out_free) begin
               seq_state_in = SQ_IDLE;
            end
         end
         default: begin
            seq_state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff    <= SQ_IDLE;
         cap_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         held_lon_ff     <= '0;
         held_lat_ff     <= '0;
         held_north_ff   <= '0;
         held_east_ff    <= '0;
         held_heading_ff <= '0;
         held_speed_ff   <= '0;
         held_fix_ff     <= '0;
      end else begin
         seq_state_ff <= seq_state_in;

         if (seq_state_ff == SQ_IDLE) begin
            kind_ff <= parse_status.kind;
            slot_ff <= '0;
         end else if (seq_state_ff == SQ_FETCH) begin
            slot_ff <= slot_ff + 4'd1;
         end

         // Read data shows up in the cycle after its address.
         cap_valid_ff <= ram_rd_en;
         cap_slot_ff  <= slot_ff;
         if (cap_valid_ff) begin
            fetch_data_ff[cap_slot_ff] <= ram_rd_data;
         end

         if (seq_state_ff == SQ_DIV1_GO && kind_ff == FRAME_VEL) begin
            quot1_ff <= speed_quot;
         end else if (seq_state_ff == SQ_DIV1_WAIT && div_done) begin
            quot1_ff <= div_quot;
         end
         if (seq_state_ff == SQ_DIV2_GO && kind_ff == FRAME_VEL) begin
            quot2_ff <= heading_quot;
         end else if (seq_state_ff == SQ_DIV2_WAIT && div_done) begin
            quot2_ff <= div_quot;
         end

         if (emit) begin
            held_lon_ff     <= nxt_lon;
            held_lat_ff     <= nxt_lat;
            held_north_ff   <= nxt_north;
            held_east_ff    <= nxt_east;
            held_heading_ff <= nxt_heading;
            held_speed_ff   <= nxt_speed;
            held_fix_ff     <= nxt_fix;

            rsp_frame_type     <= kind_ff;
            rsp_time_of_week   <= word0;
            rsp_longitude      <= nxt_lon;
            rsp_latitude       <= nxt_lat;
            rsp_north_distance <= nxt_north;
            rsp_east_distance  <= nxt_east;
            rsp_heading        <= nxt_heading;
            rsp_ground_speed   <= nxt_speed;
            rsp_fix_type       <= nxt_fix;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (seq_state_ff == SQ_DIV1_WAIT || seq_state_ff == SQ_DIV2_WAIT))
      else $error("divider finished outside a wait state");

   // A new result appears only out of the emit stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(seq_state_ff == SQ_EMIT))
      else $error("result raised outside the emit stage");

   // The payload buffer is not written while a commit is reading it back.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (seq_state_ff == SQ_IDLE))
      else $error("payload write during a commit");

   // The divider never starts with a zero divisor.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_req.divisor != '0))
      else $error("divider started with a zero divisor");

endmodule

`default_nettype wire
